### src/pwli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwli_pkg
// Shared types, constants and codes of the piecewise linear interpolator.
// ----------------------------------------------------------------------------

package pwli_pkg;

	localparam int VALUE_W    = 32;
	localparam int MAX_POINTS = 256;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int NPTS_W     = 9;
	localparam int PROD_W     = 2 * VALUE_W;
	localparam int MUL_STEPS  = VALUE_W;
	localparam int DIV_STEPS  = PROD_W;
	localparam int STEP_CNT_W = $clog2(DIV_STEPS);

	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int REG_IDX_BIT = 2;

	localparam logic [NPTS_W-1:0] POINTS_RESET = NPTS_W'(2);

	localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	// register indexes
	localparam logic REG_POINTS = 1'b0;
	localparam logic REG_EXTRAP = 1'b1;

	// item actions
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef struct packed {
		logic                      action;
		logic [7:0]                point_index;
		logic signed [VALUE_W-1:0] x_value;
		logic signed [VALUE_W-1:0] y_value;
	} item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] y_result;
		logic [7:0]                segment_index;
		logic                      zero_width_error;
	} result_t;

	typedef struct packed {
		logic                      en;
		logic [IDX_W-1:0]          addr;
		logic signed [VALUE_W-1:0] x;
		logic signed [VALUE_W-1:0] y;
	} tbl_wr_t;

	typedef struct packed {
		logic               start;
		logic [VALUE_W-1:0] mdy;
		logic [VALUE_W-1:0] mdt;
		logic [VALUE_W-1:0] mdx;
	} md_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] quot;
	} md_resp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK,
		ST_WALK,
		ST_RDL,
		ST_RDR,
		ST_PREP,
		ST_DIFF,
		ST_CALC,
		ST_FIN
	} seq_state_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV,
		MD_DONE
	} md_state_t;

endpackage

### src/pwli_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwli_table
// Breakpoint storage: x and y memories, one write and one registered read.
// ----------------------------------------------------------------------------

module pwli_table (
	input  logic                               clk,
	input  pwli_pkg::tbl_wr_t                  wr,
	input  logic [pwli_pkg::IDX_W-1:0]         rd_addr,
	output logic signed [pwli_pkg::VALUE_W-1:0] rd_x,
	output logic signed [pwli_pkg::VALUE_W-1:0] rd_y
);

	logic [pwli_pkg::VALUE_W-1:0] x_mem [pwli_pkg::MAX_POINTS];
	logic [pwli_pkg::VALUE_W-1:0] y_mem [pwli_pkg::MAX_POINTS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			x_mem[wr.addr] <= wr.x;
			y_mem[wr.addr] <= wr.y;
		end
	end

	always_ff @(posedge clk) begin
		rd_x <= x_mem[rd_addr];
		rd_y <= y_mem[rd_addr];
	end

endmodule

### src/pwli_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwli_muldiv
// Shared 33-bit adder reused for a shift-add multiply of |dy| * |dt|
// followed by a restoring divide of the product by |dx|.
// ----------------------------------------------------------------------------

module pwli_muldiv (
	input  logic               clk,
	input  logic               arst_n,
	input  pwli_pkg::md_req_t  req,
	output pwli_pkg::md_resp_t resp
);

	localparam int VW = pwli_pkg::VALUE_W;
	localparam int PW = pwli_pkg::PROD_W;
	localparam int CW = pwli_pkg::STEP_CNT_W;

	pwli_pkg::md_state_t state_q, state_d;

	logic [CW-1:0] cnt_q;
	logic [PW-1:0] p_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] a_q;
	logic [VW-1:0] d_q;

	// shared adder
	logic          alu_sub;
	logic [VW:0]   alu_a;
	logic [VW:0]   alu_b;
	logic [VW+1:0] alu_sum;

	logic          cnt_last;

	always_comb begin
		alu_sub = (state_q == pwli_pkg::MD_DIV);
		if (alu_sub) begin
			alu_a = {rem_q, p_q[PW-1]};
			alu_b = {1'b0, d_q};
		end else begin
			alu_a = {1'b0, p_q[PW-1:VW]};
			alu_b = {1'b0, a_q};
		end
		alu_sum = {1'b0, alu_a} + (alu_sub ? ~{1'b0, alu_b} : {1'b0, alu_b})
			+ (VW+2)'(alu_sub);
	end

	always_comb begin
		state_d  = state_q;
		cnt_last = 1'b0;
		unique case (state_q)
			pwli_pkg::MD_IDLE: begin
				if (req.start) begin
					state_d = pwli_pkg::MD_MUL;
				end
			end
			pwli_pkg::MD_MUL: begin
				cnt_last = (cnt_q == CW'(pwli_pkg::MUL_STEPS - 1));
				if (cnt_last) begin
					state_d = pwli_pkg::MD_DIV;
				end
			end
			pwli_pkg::MD_DIV: begin
				cnt_last = (cnt_q == CW'(pwli_pkg::DIV_STEPS - 1));
				if (cnt_last) begin
					state_d = pwli_pkg::MD_DONE;
				end
			end
			pwli_pkg::MD_DONE: begin
				state_d = pwli_pkg::MD_IDLE;
			end
			default: begin
				state_d = pwli_pkg::MD_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pwli_pkg::MD_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == pwli_pkg::MD_IDLE || cnt_last) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			pwli_pkg::MD_IDLE: begin
				if (req.start) begin
					p_q   <= {{VW{1'b0}}, req.mdt};
					a_q   <= req.mdy;
					d_q   <= req.mdx;
					rem_q <= '0;
				end
			end
			pwli_pkg::MD_MUL: begin
				if (p_q[0]) begin
					p_q <= {alu_sum[VW:0], p_q[VW-1:1]};
				end else begin
					p_q <= {1'b0, p_q[PW-1:VW], p_q[VW-1:1]};
				end
			end
			pwli_pkg::MD_DIV: begin
				// no borrow: the divisor fits, quotient bit is one
				if (!alu_sum[VW+1]) begin
					rem_q <= alu_sum[VW-1:0];
					p_q   <= {p_q[PW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[VW-2:0], p_q[PW-1]};
					p_q   <= {p_q[PW-2:0], 1'b0};
				end
			end
			pwli_pkg::MD_DONE: begin
				p_q <= p_q;
			end
			default: begin
				p_q <= p_q;
			end
		endcase
	end

	assign resp.done = (state_q == pwli_pkg::MD_DONE);
	assign resp.quot = p_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> (state_q == pwli_pkg::MD_IDLE))
		else $error("muldiv started while busy");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pwli_pkg::MD_DIV) |-> (rem_q < d_q))
		else $error("partial remainder not below divisor");
`endif

endmodule

### src/pwli_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwli_seq
// Sequencer: takes load and query beats, walks the table for the segment,
// reads its end points, clamps, hands the magnitudes to the muldiv unit and
// saturates the result into the output register.
// ----------------------------------------------------------------------------

module pwli_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  pwli_pkg::item_t              item,
	output logic                         result_valid,
	input  logic                         result_stall,
	output pwli_pkg::result_t            result,
	input  logic [pwli_pkg::NPTS_W-1:0]  points_in_use,
	input  logic                         extrapolate_enable,
	output pwli_pkg::tbl_wr_t            tbl_wr,
	output logic [pwli_pkg::IDX_W-1:0]   rd_addr,
	input  logic signed [pwli_pkg::VALUE_W-1:0] rd_x,
	input  logic signed [pwli_pkg::VALUE_W-1:0] rd_y,
	output pwli_pkg::md_req_t            md_req,
	input  pwli_pkg::md_resp_t           md_resp
);

	localparam int VW = pwli_pkg::VALUE_W;
	localparam int IW = pwli_pkg::IDX_W;
	localparam int NW = pwli_pkg::NPTS_W;

	pwli_pkg::seq_state_t state_q, state_d;

	logic                 out_valid_q;
	pwli_pkg::result_t    out_q;

	logic signed [VW-1:0] x_q;
	logic [IW-1:0]        nm2_q;
	logic [IW-1:0]        seg_q;
	logic signed [VW-1:0] xl_q, yl_q, xr_q, yr_q;
	logic                 err_q;
	logic                 neg_q;

	logic                 accept;
	logic [IW-1:0]        nm2_c;
	logic                 walk_go;
	logic                 out_free;
	logic                 out_load;

	logic signed [VW-1:0] yl_c, yr_c;
	logic [VW:0]          dy_c, dt_c, dx_c;

	logic [VW+1:0]        sum_c;
	logic                 sat_c;
	logic signed [VW-1:0] y_c;

	// sign and magnitude of a - b
	function automatic logic [VW:0] absdiff(input logic signed [VW-1:0] a,
	                                        input logic signed [VW-1:0] b);
		logic [VW:0] dab;
		logic [VW:0] dba;
		dab = {a[VW-1], a} - {b[VW-1], b};
		dba = {b[VW-1], b} - {a[VW-1], a};
		return dab[VW] ? {1'b1, dba[VW-1:0]} : {1'b0, dab[VW-1:0]};
	endfunction

	assign item_stall   = (state_q != pwli_pkg::ST_IDLE);
	assign accept       = item_valid && !item_stall;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_comb begin
		if (points_in_use < NW'(2)) begin
			nm2_c = '0;
		end else if (points_in_use > NW'(pwli_pkg::MAX_POINTS)) begin
			nm2_c = IW'(pwli_pkg::MAX_POINTS - 2);
		end else begin
			nm2_c = IW'(points_in_use - NW'(2));
		end
	end

	always_comb begin
		tbl_wr.en   = accept && (item.action == pwli_pkg::ACT_LOAD)
			&& ({1'b0, item.point_index} < NW'(pwli_pkg::MAX_POINTS));
		tbl_wr.addr = IW'(item.point_index);
		tbl_wr.x    = item.x_value;
		tbl_wr.y    = item.y_value;
	end

	// clamping and segment magnitudes
	always_comb begin
		yr_c = (!extrapolate_enable && (x_q < xl_q)) ? yl_q : yr_q;
		yl_c = (!extrapolate_enable && (xr_q < x_q)) ? yr_c : yl_q;
		dy_c = absdiff(yr_q, yl_q);
		dt_c = absdiff(x_q, xl_q);
		dx_c = absdiff(xr_q, xl_q);
	end

	always_comb begin
		md_req.start = (state_q == pwli_pkg::ST_DIFF);
		md_req.mdy   = dy_c[VW-1:0];
		md_req.mdt   = dt_c[VW-1:0];
		md_req.mdx   = dx_c[VW-1:0];
	end

	// final add with saturation
	always_comb begin
		if (neg_q) begin
			sum_c = {yl_q[VW-1], yl_q[VW-1], yl_q} - {2'b00, md_resp.quot[VW-1:0]};
		end else begin
			sum_c = {yl_q[VW-1], yl_q[VW-1], yl_q} + {2'b00, md_resp.quot[VW-1:0]};
		end
		sat_c = (md_resp.quot[pwli_pkg::PROD_W-1:VW] != '0)
			|| (sum_c[VW+1] != sum_c[VW-1]) || (sum_c[VW] != sum_c[VW-1]);
		if (err_q) begin
			y_c = yl_q;
		end else if (sat_c) begin
			y_c = neg_q ? pwli_pkg::VAL_MIN : pwli_pkg::VAL_MAX;
		end else begin
			y_c = sum_c[VW-1:0];
		end
	end

	always_comb begin
		state_d  = state_q;
		rd_addr  = seg_q;
		walk_go  = (seg_q < nm2_q) && (rd_x < x_q);
		out_free = !out_valid_q || !result_stall;
		out_load = 1'b0;
		unique case (state_q)
			pwli_pkg::ST_IDLE: begin
				rd_addr = nm2_c;
				if (accept && item.action == pwli_pkg::ACT_QUERY) begin
					state_d = pwli_pkg::ST_CHK;
				end
			end
			pwli_pkg::ST_CHK: begin
				// at or past the second-last x: last segment
				if (!(x_q < rd_x)) begin
					rd_addr = nm2_q;
					state_d = pwli_pkg::ST_RDL;
				end else begin
					rd_addr = IW'(1);
					state_d = pwli_pkg::ST_WALK;
				end
			end
			pwli_pkg::ST_WALK: begin
				if (walk_go) begin
					rd_addr = seg_q + IW'(2);
				end else begin
					rd_addr = seg_q;
					state_d = pwli_pkg::ST_RDL;
				end
			end
			pwli_pkg::ST_RDL: begin
				rd_addr = seg_q + IW'(1);
				state_d = pwli_pkg::ST_RDR;
			end
			pwli_pkg::ST_RDR: begin
				state_d = pwli_pkg::ST_PREP;
			end
			pwli_pkg::ST_PREP: begin
				state_d = (xr_q == xl_q) ? pwli_pkg::ST_FIN : pwli_pkg::ST_DIFF;
			end
			pwli_pkg::ST_DIFF: begin
				state_d = pwli_pkg::ST_CALC;
			end
			pwli_pkg::ST_CALC: begin
				if (md_resp.done) begin
					state_d = pwli_pkg::ST_FIN;
				end
			end
			pwli_pkg::ST_FIN: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = pwli_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pwli_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pwli_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= item.x_value;
			nm2_q <= nm2_c;
		end
		if (state_q == pwli_pkg::ST_CHK) begin
			seg_q <= (!(x_q < rd_x)) ? nm2_q : '0;
		end
		if (state_q == pwli_pkg::ST_WALK && walk_go) begin
			seg_q <= seg_q + IW'(1);
		end
		if (state_q == pwli_pkg::ST_RDL) begin
			xl_q <= rd_x;
			yl_q <= rd_y;
		end
		if (state_q == pwli_pkg::ST_RDR) begin
			xr_q <= rd_x;
			yr_q <= rd_y;
		end
		if (state_q == pwli_pkg::ST_PREP) begin
			yl_q  <= yl_c;
			yr_q  <= yr_c;
			err_q <= (xr_q == xl_q);
		end
		if (state_q == pwli_pkg::ST_DIFF) begin
			neg_q <= dy_c[VW] ^ dt_c[VW] ^ dx_c[VW];
		end
		if (out_load) begin
			out_q.y_result         <= y_c;
			out_q.segment_index    <= 8'(seg_q);
			out_q.zero_width_error <= err_q;
		end
	end

`ifndef SYNTHESIS
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pwli_pkg::ST_WALK) |-> (seg_q <= nm2_q))
		else $error("segment walk ran past the last segment");

	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		md_resp.done |-> (state_q == pwli_pkg::ST_CALC))
		else $error("muldiv finished outside the wait state");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == pwli_pkg::ST_FIN))
		else $error("result register loaded outside the final state");
`endif

endmodule

### src/piecewise_linear_interpolator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_top
// Piecewise linear table interpolator, Q16.16, with an APB register port.
// ----------------------------------------------------------------------------
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------
//   item     | item_valid/item_stall  | action, point_index, x_value, y_value
//   result   | result_valid/result_stall | y_result, segment_index, zero_width_error
//   config   | psel/penable/pwrite    | paddr, pwdata, prdata (pready high)
//
// a load beat is written into the table as it is accepted; a query beat walks
// the table for its segment (no walk at or past the second-last x), reads its
// end points, then runs the 32 multiply steps, 64 divide steps and done state
// on the shared adder, which a zero-width segment skips, before its result is loaded
// item_stall is high from a query beat until its result enters the output
// register; a stalled result holds the sequencer in its final state
// reset clears control and sets the registers to two points, no extrapolation; the tables are undefined until loaded

module piecewise_linear_interpolator_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  pwli_pkg::item_t                     item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output pwli_pkg::result_t                   result,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pwli_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [pwli_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [pwli_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                pready
);

	localparam int NW = pwli_pkg::NPTS_W;
	localparam int DW = pwli_pkg::CFG_DATA_W;

	logic [NW-1:0] points_q;
	logic          extrap_q;
	logic          apb_wr;

	pwli_pkg::tbl_wr_t            tbl_wr;
	logic [pwli_pkg::IDX_W-1:0]   rd_addr;
	logic signed [pwli_pkg::VALUE_W-1:0] rd_x;
	logic signed [pwli_pkg::VALUE_W-1:0] rd_y;
	pwli_pkg::md_req_t            md_req;
	pwli_pkg::md_resp_t           md_resp;

	assign pready = 1'b1;
	assign apb_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q <= pwli_pkg::POINTS_RESET;
			extrap_q <= 1'b0;
		end else if (apb_wr) begin
			unique case (paddr[pwli_pkg::REG_IDX_BIT])
				pwli_pkg::REG_POINTS: points_q <= pwdata[NW-1:0];
				pwli_pkg::REG_EXTRAP: extrap_q <= pwdata[0];
				default: points_q <= points_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[pwli_pkg::REG_IDX_BIT])
			pwli_pkg::REG_POINTS: prdata = DW'(points_q);
			pwli_pkg::REG_EXTRAP: prdata = DW'(extrap_q);
			default:              prdata = '0;
		endcase
	end

	pwli_table u_table (
		.clk     (clk),
		.wr      (tbl_wr),
		.rd_addr (rd_addr),
		.rd_x    (rd_x),
		.rd_y    (rd_y)
	);

	pwli_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.resp   (md_resp)
	);

	pwli_seq u_seq (
		.clk                (clk),
		.arst_n             (arst_n),
		.item_valid         (item_valid),
		.item_stall         (item_stall),
		.item               (item),
		.result_valid       (result_valid),
		.result_stall       (result_stall),
		.result             (result),
		.points_in_use      (points_q),
		.extrapolate_enable (extrap_q),
		.tbl_wr             (tbl_wr),
		.rd_addr            (rd_addr),
		.rd_x               (rd_x),
		.rd_y               (rd_y),
		.md_req             (md_req),
		.md_resp            (md_resp)
	);

endmodule

### sim/piecewise_linear_interpolator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_top_tb
// Self-checking bench for the breakpoint table interpolator. A short directed
// table is run first: clamping, extrapolation, saturation, zero-width and
// unsorted segments, and out-of-range point counts. Random traffic follows
// over several register settings. Each query beat is predicted at its input
// handshake and checked field by field in order at the result handshake.
// ----------------------------------------------------------------------------

module piecewise_linear_interpolator_top_tb;

	localparam int LIMIT        = 1500000;
	localparam int DRAIN_CYCLES = 400;
	localparam int HOLD_CYCLES  = 3000;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 46;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		pwli_pkg::item_t   it;
		logic              typed;
		pwli_pkg::result_t want;
	} feed_t;

	typedef struct packed {
		row_kind_t                   kind;
		logic                        cfg_reg;
		logic [pwli_pkg::NPTS_W-1:0] cfg_val;
		feed_t                       f;
	} drow_t;

	logic                            clk          = 1'b0;
	logic                            arst_n       = 1'b0;
	logic                            item_valid   = 1'b0;
	logic                            item_stall;
	pwli_pkg::item_t                 item         = '0;
	logic                            result_valid;
	logic                            result_stall = 1'b0;
	pwli_pkg::result_t               result;
	logic                            psel         = 1'b0;
	logic                            penable      = 1'b0;
	logic                            pwrite       = 1'b0;
	logic [pwli_pkg::CFG_ADDR_W-1:0] paddr        = '0;
	logic [pwli_pkg::CFG_DATA_W-1:0] pwdata       = '0;
	logic [pwli_pkg::CFG_DATA_W-1:0] prdata;
	logic                            pready;

	// predictor state
	logic signed [pwli_pkg::VALUE_W-1:0] x_tab [pwli_pkg::MAX_POINTS];
	logic signed [pwli_pkg::VALUE_W-1:0] y_tab [pwli_pkg::MAX_POINTS];
	logic [pwli_pkg::NPTS_W-1:0]         pts_cfg    = pwli_pkg::POINTS_RESET;
	logic                                extrap_cfg = 1'b0;

	// generator view of the table, used only to shape stimulus
	logic signed [pwli_pkg::VALUE_W-1:0] plan_x [pwli_pkg::MAX_POINTS];

	feed_t             item_feed [$];
	pwli_pkg::result_t interp_q [$];
	drow_t             dir_rows [$];
	feed_t             shown;
	int                in_flight   = 0;
	int                fails       = 0;
	int                cycles      = 0;
	int                sender_idle = 0;
	int                recv_idle   = 0;
	logic              hold_go     = 1'b0;
	logic              long_hold   = 1'b0;

	piecewise_linear_interpolator_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #10 clk = ~clk;

	function automatic pwli_pkg::result_t interpolate(
			logic signed [pwli_pkg::VALUE_W-1:0] qx);
		int                                  n;
		int                                  i;
		logic signed [pwli_pkg::VALUE_W-1:0] xl, yl, xr, yr;
		longint                              dy, dt, dx;
		logic signed [127:0]                 prod, quo, sum;
		pwli_pkg::result_t                   r;
		n = int'(pts_cfg);
		if (n < 2) n = 2;
		if (n > pwli_pkg::MAX_POINTS) n = pwli_pkg::MAX_POINTS;
		i = 0;
		if (qx >= x_tab[n-2]) begin
			i = n - 2;
		end else begin
			while (i < n - 2 && x_tab[i+1] < qx) i++;
		end
		xl = x_tab[i];
		yl = y_tab[i];
		xr = x_tab[i+1];
		yr = y_tab[i+1];
		if (!extrap_cfg) begin
			if (qx < xl) yr = yl;
			if (xr < qx) yl = yr;
		end
		r.segment_index = 8'(i);
		if (xr == xl) begin
			r.zero_width_error = 1'b1;
			r.y_result = yl;
		end else begin
			r.zero_width_error = 1'b0;
			dy = longint'(yr) - longint'(yl);
			dt = longint'(qx) - longint'(xl);
			dx = longint'(xr) - longint'(xl);
			prod = 128'(dy) * 128'(dt);
			// signed division truncates toward zero
			quo = prod / 128'(dx);
			sum = 128'(yl) + quo;
			if (sum > pwli_pkg::VAL_MAX) r.y_result = pwli_pkg::VAL_MAX;
			else if (sum < pwli_pkg::VAL_MIN) r.y_result = pwli_pkg::VAL_MIN;
			else r.y_result = pwli_pkg::VALUE_W'(sum);
		end
		return r;
	endfunction

	function automatic logic signed [pwli_pkg::VALUE_W-1:0] fx(int whole);
		return 32'(whole) <<< 16;
	endfunction

	function automatic longint pick(longint lo, longint hi);
		if (hi <= lo) return lo;
		return lo + longint'({32'd0, $urandom}) % (hi - lo + 1);
	endfunction

	function automatic logic signed [pwli_pkg::VALUE_W-1:0] rand_y();
		if ($urandom_range(1)) return $urandom;
		return 32'($urandom_range(1 << 25)) - 32'(1 << 24);
	endfunction

	function automatic feed_t mk(logic act, logic [7:0] idx,
			logic signed [pwli_pkg::VALUE_W-1:0] xv,
			logic signed [pwli_pkg::VALUE_W-1:0] yv, logic typed,
			pwli_pkg::result_t want);
		feed_t f;
		f.it.action      = act;
		f.it.point_index = idx;
		f.it.x_value     = xv;
		f.it.y_value     = yv;
		f.typed          = typed;
		f.want           = want;
		return f;
	endfunction

	function automatic void enqueue(feed_t f);
		item_feed = {item_feed, f};
		in_flight++;
	endfunction

	function automatic void add_load(logic [7:0] idx, logic signed [pwli_pkg::VALUE_W-1:0] xv,
			logic signed [pwli_pkg::VALUE_W-1:0] yv);
		drow_t d;
		d = '0;
		d.kind = ROW_ITEM;
		d.f = mk(pwli_pkg::ACT_LOAD, idx, xv, yv, 1'b0, '0);
		dir_rows = {dir_rows, d};
	endfunction

	function automatic void add_query(logic signed [pwli_pkg::VALUE_W-1:0] xv);
		drow_t d;
		d = '0;
		d.kind = ROW_ITEM;
		// index and y are don't-care on a query
		d.f = mk(pwli_pkg::ACT_QUERY, 8'($urandom), xv, $urandom, 1'b0, '0);
		dir_rows = {dir_rows, d};
	endfunction

	function automatic void add_check(logic signed [pwli_pkg::VALUE_W-1:0] xv,
			logic signed [pwli_pkg::VALUE_W-1:0] yexp, logic [7:0] seg, logic err);
		drow_t             d;
		pwli_pkg::result_t w;
		d = '0;
		w.y_result = yexp;
		w.segment_index = seg;
		w.zero_width_error = err;
		d.kind = ROW_ITEM;
		d.f = mk(pwli_pkg::ACT_QUERY, 8'($urandom), xv, $urandom, 1'b1, w);
		dir_rows = {dir_rows, d};
	endfunction

	function automatic void add_cfg(logic which, logic [pwli_pkg::NPTS_W-1:0] val);
		drow_t d;
		d = '0;
		d.kind = ROW_CFG;
		d.cfg_reg = which;
		d.cfg_val = val;
		dir_rows = {dir_rows, d};
	endfunction

	task automatic cfg_write(logic which, logic [pwli_pkg::NPTS_W-1:0] val);
		logic [pwli_pkg::CFG_DATA_W-1:0] word;
		// upper bits are noise, the register keeps only its own width
		word = $urandom;
		if (which == pwli_pkg::REG_POINTS) word[pwli_pkg::NPTS_W-1:0] = val;
		else word[0] = val[0];
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= pwli_pkg::CFG_ADDR_W'(which) << pwli_pkg::REG_IDX_BIT;
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (which == pwli_pkg::REG_POINTS) pts_cfg = word[pwli_pkg::NPTS_W-1:0];
		else extrap_cfg = word[0];
	endtask

	task automatic wait_drained();
		while (in_flight != 0 || interp_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// input side: predict on each accepted beat, then offer the next one
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				if (shown.it.action == pwli_pkg::ACT_LOAD) begin
					x_tab[shown.it.point_index] = shown.it.x_value;
					y_tab[shown.it.point_index] = shown.it.y_value;
				end else if (shown.typed) begin
					interp_q = {interp_q, shown.want};
				end else begin
					interp_q = {interp_q, interpolate(shown.it.x_value)};
				end
				in_flight--;
			end
			if (!item_valid || !item_stall) begin
				if (item_feed.size() != 0 && $urandom_range(99) >= sender_idle) begin
					shown = item_feed.pop_front();
					item_valid <= 1'b1;
					item <= shown.it;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// output side
	always @(posedge clk) begin : rx
		pwli_pkg::result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (interp_q.size() == 0) begin
					$error("result beat with no query outstanding");
					fails++;
				end else begin
					want = interp_q.pop_front();
					if (result.y_result !== want.y_result) begin
						$error("y_result: expected %h, got %h", want.y_result, result.y_result);
						fails++;
					end
					if (result.segment_index !== want.segment_index) begin
						$error("segment_index: expected %0d, got %0d",
							want.segment_index, result.segment_index);
						fails++;
					end
					if (result.zero_width_error !== want.zero_width_error) begin
						$error("zero_width_error: expected %b, got %b",
							want.zero_width_error, result.zero_width_error);
						fails++;
					end
				end
			end
			result_stall <= long_hold || ($urandom_range(99) < recv_idle);
		end
	end

	// one long receiver hold-off so the block fills and stalls its input
	initial begin
		wait (hold_go);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : sequencer
		drow_t                       row;
		int                          k, r, sel, n_eff;
		longint                      xv, lo, hi;
		logic [pwli_pkg::NPTS_W-1:0] pts;
		logic                        ex;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// two-point line through (0,0) and (10,100), clamped then extended
		add_load(8'd0, fx(0), fx(0));
		add_load(8'd1, fx(10), fx(100));
		add_check(fx(5), fx(50), 8'd0, 1'b0);
		add_check(fx(-5), fx(0), 8'd0, 1'b0);
		add_check(fx(20), fx(100), 8'd0, 1'b0);
		add_check(pwli_pkg::VAL_MIN, fx(0), 8'd0, 1'b0);
		add_check(pwli_pkg::VAL_MAX, fx(100), 8'd0, 1'b0);
		add_cfg(pwli_pkg::REG_EXTRAP, 9'd1);
		add_check(fx(20), fx(200), 8'd0, 1'b0);
		add_check(fx(-5), fx(-50), 8'd0, 1'b0);
		add_check(pwli_pkg::VAL_MAX, pwli_pkg::VAL_MAX, 8'd0, 1'b0);
		add_check(pwli_pkg::VAL_MIN, pwli_pkg::VAL_MIN, 8'd0, 1'b0);
		// full-scale segment, falling
		add_load(8'd0, pwli_pkg::VAL_MIN, pwli_pkg::VAL_MAX);
		add_load(8'd1, pwli_pkg::VAL_MAX, pwli_pkg::VAL_MIN);
		add_query(32'sd0);
		add_check(pwli_pkg::VAL_MAX, pwli_pkg::VAL_MIN, 8'd0, 1'b0);
		// zero-width segment, with and without clamping
		add_load(8'd0, fx(3), fx(-7));
		add_load(8'd1, fx(3), fx(9));
		add_check(fx(1), fx(-7), 8'd0, 1'b1);
		add_cfg(pwli_pkg::REG_EXTRAP, 9'd0);
		add_query(fx(5));
		// unsorted four-point table
		add_load(8'd2, fx(1), fx(1));
		add_load(8'd3, fx(2), fx(4));
		add_cfg(pwli_pkg::REG_POINTS, 9'd4);
		add_query(fx(2) + 32'sh8000);
		add_query(32'sd0);
		// point counts below two act as two
		add_cfg(pwli_pkg::REG_POINTS, 9'd0);
		add_query(fx(2));
		add_cfg(pwli_pkg::REG_POINTS, 9'd1);
		add_query(fx(4));

		sender_idle = 23;
		recv_idle   = 84;
		foreach (dir_rows[j]) begin
			row = dir_rows[j];
			if (row.kind == ROW_CFG) begin
				wait_drained();
				cfg_write(row.cfg_reg, row.cfg_val);
			end else begin
				enqueue(row.f);
			end
		end
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			if (p == 0) begin
				// sorted table with random spacing, a few near-equal neighbors
				xv = -longint'($urandom_range(1 << 30));
				for (k = 0; k < pwli_pkg::MAX_POINTS; k++) begin
					if (k > 0) begin
						if ($urandom_range(99) < 8) xv += longint'($urandom_range(2));
						else xv += longint'($urandom_range(1 << 22, 1));
					end
					plan_x[k] = 32'(xv);
					enqueue(mk(pwli_pkg::ACT_LOAD, 8'(k), 32'(xv), rand_y(), 1'b0, '0));
				end
				wait_drained();
			end
			case (p)
				0: begin pts = 9'd2;   ex = 1'b0; end
				1: begin pts = 9'd256; ex = 1'b1; end
				2: begin pts = 9'd0;   ex = 1'b1; end
				3: begin pts = 9'd511; ex = 1'b0; end
				4: begin pts = 9'($urandom_range(12, 3)); ex = 1'b1; end
				5: begin pts = 9'($urandom_range(40, 2)); ex = 1'b0; end
				6: begin pts = 9'd1;   ex = 1'b0; end
				7: begin pts = 9'd257; ex = 1'b1; end
				8: begin pts = 9'($urandom_range(24, 4)); ex = 1'($urandom); end
				default: begin pts = 9'($urandom_range(256, 2)); ex = 1'($urandom); end
			endcase
			cfg_write(pwli_pkg::REG_POINTS, pts);
			cfg_write(pwli_pkg::REG_EXTRAP, ex);
			n_eff = int'(pts);
			if (n_eff < 2) n_eff = 2;
			if (n_eff > pwli_pkg::MAX_POINTS) n_eff = pwli_pkg::MAX_POINTS;
			if (p < 3) begin
				sender_idle = 23;
				recv_idle   = 84;
			end else if (p < 6) begin
				sender_idle = 84;
				recv_idle   = 23;
			end else begin
				sender_idle = 0;
				recv_idle   = 0;
			end
			if (p == 6) hold_go = 1'b1;

			for (int j = 0; j < PHASE_ITEMS; j++) begin
				r = $urandom_range(99);
				if (r < 30) begin
					k = ($urandom_range(99) < 80) ? $urandom_range(n_eff - 1)
						: $urandom_range(pwli_pkg::MAX_POINTS - 1);
					lo = (k > 0) ? longint'(plan_x[k-1]) : longint'(plan_x[k]) - 1024;
					hi = (k < pwli_pkg::MAX_POINTS - 1) ? longint'(plan_x[k+1])
						: longint'(plan_x[k]) + 1024;
					sel = $urandom_range(99);
					if (sel < 70) xv = pick(lo, hi);
					else if (sel < 85) xv = lo;
					else xv = longint'(int'($urandom));
					plan_x[k] = 32'(xv);
					enqueue(mk(pwli_pkg::ACT_LOAD, 8'(k), 32'(xv), rand_y(), 1'b0, '0));
				end else begin
					sel = $urandom_range(99);
					if (sel < 10) begin
						xv = longint'(int'($urandom));
					end else if (sel < 25) begin
						xv = longint'(plan_x[$urandom_range(n_eff - 1)]);
					end else if (sel < 35) begin
						if ($urandom_range(1))
							xv = longint'(plan_x[0]) - longint'($urandom_range(1 << 20));
						else
							xv = longint'(plan_x[n_eff-1]) + longint'($urandom_range(1 << 20));
					end else begin
						k = $urandom_range(n_eff - 2);
						xv = pick(longint'(plan_x[k]), longint'(plan_x[k+1]));
					end
					enqueue(mk(pwli_pkg::ACT_QUERY, 8'($urandom), 32'(xv), rand_y(),
						1'b0, '0));
				end
			end
			wait_drained();
		end

		if (fails == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

endmodule
